>>> design/circle_point_generator_defines.svh
// Assertion macros for the circle point generator.
`ifndef CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CPG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle point generator check failed");
`define CPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle point generator check failed");
`else
`define CPG_ASSERT_SAME(lbl, ante, cons)
`define CPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/cpg_pkg.sv
// Shared types and constants of the circle point generator.
`default_nettype none
package cpg_pkg;

    localparam int PHASE_W = 32;
    localparam int CW      = 34;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    localparam logic [31:0] ATAN_PHASE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               last;
    } pt_meta_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage
`default_nettype wire

>>> design/cpg_step_div.sv
// Bit-serial divider that forms the phase step round(2^32/n).
`default_nettype none
module cpg_step_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [cpg_pkg::COUNT_W-1:0] divisor,
    output logic                             done,
    output logic [cpg_pkg::PHASE_W-1:0]      quotient
);
    import cpg_pkg::*;

    logic [PHASE_W:0]   dvd_reg, dvd_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] den_reg;
    logic [5:0]         cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[PHASE_W]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dvd_next = {1'b1, 26'd0, divisor[COUNT_W-1:1]};
            rem_next = '0;
            cnt_next = 6'd33;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, den_reg});
                dvd_next = {dvd_reg[PHASE_W-1:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
                dvd_next = {dvd_reg[PHASE_W-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (go)
            den_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[PHASE_W-1:0];
endmodule
`default_nettype wire

>>> design/cpg_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per iteration.
`default_nettype none
module cpg_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cpg_pkg::pt_meta_t             in_meta,
    input  wire logic [cpg_pkg::PHASE_W-1:0]   phase,
    output cpg_pkg::pt_meta_t                  out_meta,
    output logic signed [31:0]                 cos_val,
    output logic signed [31:0]                 sin_val
);
    import cpg_pkg::*;

    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [CW-1:0] z_reg [STEPS+1];
    logic                 flip_reg [STEPS+1];
    pt_meta_t             meta_reg [STEPS+1];
    logic [PHASE_W-1:0]   fold_sum;
    logic [PHASE_W-1:0]   folded;
    logic signed [31:0]   cos_reg, sin_reg;
    pt_meta_t             meta_out_reg;

    assign fold_sum = phase + 32'h40000000;
    assign folded   = fold_sum[PHASE_W-1] ? (phase - 32'h80000000) : phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_reg[0] <= '0;
        else
            meta_reg[0] <= in_meta;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= CW'($signed(folded));
        flip_reg[0] <= fold_sum[PHASE_W-1];
    end

    for (genvar g = 0; g < STEPS; g++)
    begin : g_stage
        logic signed [CW-1:0] dx, dy, da;
        assign dx = x_reg[g] >>> g;
        assign dy = y_reg[g] >>> g;
        assign da = CW'($signed({1'b0, ATAN_PHASE[g]}));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                meta_reg[g+1] <= '0;
            else
                meta_reg[g+1] <= meta_reg[g];
        end

        always_ff @(posedge clk)
        begin
            flip_reg[g+1] <= flip_reg[g];
            if (!z_reg[g][CW-1])
            begin
                x_reg[g+1] <= x_reg[g] - dy;
                y_reg[g+1] <= y_reg[g] + dx;
                z_reg[g+1] <= z_reg[g] - da;
            end
            else
            begin
                x_reg[g+1] <= x_reg[g] + dy;
                y_reg[g+1] <= y_reg[g] - dx;
                z_reg[g+1] <= z_reg[g] + da;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_out_reg <= '0;
        else
            meta_out_reg <= meta_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= 32'(flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS]);
        sin_reg <= 32'(flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS]);
    end

    assign out_meta = meta_out_reg;
    assign cos_val  = cos_reg;
    assign sin_val  = sin_reg;
endmodule
`default_nettype wire

>>> design/cpg_scale.sv
// Radius scaling, centre offset and saturation, two register stages.
`default_nettype none
module cpg_scale (
    input  wire logic                rst_n,
    input  wire logic                clk,
    input  wire cpg_pkg::pt_meta_t   in_meta,
    input  wire logic signed [31:0]  cos_val,
    input  wire logic signed [31:0]  sin_val,
    input  wire logic [30:0]         radius,
    input  wire logic signed [31:0]  cx,
    input  wire logic signed [31:0]  cz,
    output cpg_pkg::pt_meta_t        out_meta,
    output logic signed [31:0]       px,
    output logic signed [31:0]       pz
);
    import cpg_pkg::*;

    pt_meta_t           meta_a_reg, meta_b_reg;
    logic signed [63:0] prod_x_reg, prod_z_reg;
    logic signed [63:0] rnd_x, rnd_z;
    logic signed [34:0] sum_x, sum_z;
    logic signed [31:0] px_reg, pz_reg;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh07FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sh080000000)
            r = -32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign rnd_x = prod_x_reg + 64'sh20000000;
    assign rnd_z = prod_z_reg + 64'sh20000000;
    assign sum_x = 35'(cx) + 35'($signed(rnd_x[63:30]));
    assign sum_z = 35'(cz) + 35'($signed(rnd_z[63:30]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_a_reg <= '0;
            meta_b_reg <= '0;
        end
        else
        begin
            meta_a_reg <= in_meta;
            meta_b_reg <= meta_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= $signed({1'b0, radius}) * cos_val;
        prod_z_reg <= $signed({1'b0, radius}) * sin_val;
        px_reg     <= sat32(sum_x);
        pz_reg     <= sat32(sum_z);
    end

    assign out_meta = meta_b_reg;
    assign px       = px_reg;
    assign pz       = pz_reg;
endmodule
`default_nettype wire

>>> design/circle_point_generator.sv
// Top level: ring sequencer, step divider, CORDIC pipeline and scaler.
//
//  channel   handshake              payload
//  request   start / busy           center_x, center_y, center_z, ring_radius
//  config    point_count_we         point_count_data
//  points    point_valid strobe     point_x, point_y, point_z, point_index, last_point
//
// A ring first runs the serial step divider, then issues one point per cycle
// into a CORDIC_STEPS + 4 stage pipeline.
// busy stays high from an accepted request with a nonzero point count until the last point's beat.
// Reset clears the control state and loads point_count with 16.
// Points leave on consecutive cycles and cannot be held off.
`default_nettype none
module circle_point_generator #(
    parameter int MAX_POINTS   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic [30:0]        ring_radius,
    input  wire logic               point_count_we,
    input  wire logic [6:0]         point_count_data,
    output logic                    point_valid,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      point_z,
    output logic [5:0]              point_index,
    output logic                    last_point
);
    import cpg_pkg::*;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   point_count_reg;
    logic [COUNT_W-1:0]   n_reg, n_sat;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [PHASE_W-1:0]   step_reg;
    logic signed [31:0]   cx_reg, cy_reg, cz_reg;
    logic [30:0]          r_reg;
    logic                 accept, div_go, div_done;
    logic [PHASE_W-1:0]   div_q;
    pt_meta_t             issue_meta, cordic_meta, out_meta;
    logic signed [31:0]   cos_val, sin_val;

    assign n_sat  = (point_count_reg > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS)
                                                             : point_count_reg;
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        div_go     = 1'b0;
        issue_meta = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && n_sat != '0)
                begin
                    div_go     = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                idx_next   = '0;
                phase_next = '0;
                if (div_done)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                issue_meta.valid = 1'b1;
                issue_meta.index = idx_reg;
                issue_meta.last  = ({1'b0, idx_reg} == n_reg - 7'd1);
                idx_next   = idx_reg + 6'd1;
                phase_next = phase_reg + step_reg;
                if (issue_meta.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_meta.valid && out_meta.last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= 7'd16;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (point_count_we)
                point_count_reg <= point_count_data;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        if (div_done)
            step_reg <= div_q;
        if (accept)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            cz_reg <= center_z;
            r_reg  <= ring_radius;
            n_reg  <= n_sat;
        end
    end

    cpg_step_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .divisor  (n_sat),
        .done     (div_done),
        .quotient (div_q)
    );

    cpg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_meta  (issue_meta),
        .phase    (phase_reg),
        .out_meta (cordic_meta),
        .cos_val  (cos_val),
        .sin_val  (sin_val)
    );

    cpg_scale u_scale (
        .rst_n    (rst_n),
        .clk      (clk),
        .in_meta  (cordic_meta),
        .cos_val  (cos_val),
        .sin_val  (sin_val),
        .radius   (r_reg),
        .cx       (cx_reg),
        .cz       (cz_reg),
        .out_meta (out_meta),
        .px       (point_x),
        .pz       (point_z)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign point_valid = out_meta.valid;
    assign point_y     = cy_reg;
    assign point_index = out_meta.index;
    assign last_point  = out_meta.last;

`include "circle_point_generator_defines.svh"

    `CPG_ASSERT_SAME(a_beat_while_busy, point_valid, busy)
    `CPG_ASSERT_NEXT(a_idle_after_last, point_valid && last_point, !busy)
    `CPG_ASSERT_NEXT(a_points_contiguous, point_valid && !last_point, point_valid)
    `CPG_ASSERT_NEXT(a_index_advances, point_valid && !last_point,
                     point_index == $past(point_index) + 6'd1)

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking bench for circle_point_generator: directed and random rings against a CORDIC point predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpg_pkg::*;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        radius;
    } ring_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         index;
        logic               last;
    } point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] center_x = '0;
    logic signed [31:0] center_y = '0;
    logic signed [31:0] center_z = '0;
    logic [30:0]        ring_radius = '0;
    logic               point_count_we = 1'b0;
    logic [6:0]         point_count_data = '0;
    logic               point_valid;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [5:0]         point_index;
    logic               last_point;

    ring_t  ring_requests_q[$];
    point_t ring_points_q[$];
    ring_t  active_ring;
    logic [6:0] count_mirror = 7'd16;
    int unsigned sender_idle_pct = 0;
    int unsigned mismatches = 0;

    circle_point_generator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .ring_radius(ring_radius),
        .point_count_we(point_count_we), .point_count_data(point_count_data),
        .point_valid(point_valid), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .point_index(point_index), .last_point(last_point)
    );

    always #10 clk = ~clk;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void predict_ring_points(ring_t rq, logic [6:0] cnt);
        longint unsigned n;
        logic [31:0] step;
        logic [31:0] phase;
        logic [31:0] q;
        logic [63:0] wide;
        logic flip;
        longint x, y, z, dx, dy, r, ox, oz;
        point_t p;
        n = (cnt > 7'd64) ? 64 : cnt;
        if (n == 0)
            return;
        wide = ((64'd1 << 32) + n / 2) / n;
        step = wide[31:0];
        r = longint'({33'd0, rq.radius});
        for (longint unsigned i = 0; i < n; i++) begin
            wide = i * step;
            phase = wide[31:0];
            flip = 1'b0;
            q = phase;
            if (((phase + 32'h40000000) & 32'h80000000) != 0) begin
                q = phase - 32'h80000000;
                flip = 1'b1;
            end
            x = longint'(CORDIC_GAIN);
            y = 0;
            z = longint'(signed'(q));
            for (int k = 0; k < 16; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'({32'd0, ATAN_PHASE[k]});
                end
                else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'({32'd0, ATAN_PHASE[k]});
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            ox = (r * x + (64'sd1 <<< 29)) >>> 30;
            oz = (r * y + (64'sd1 <<< 29)) >>> 30;
            p.x = clamp32(longint'(rq.cx) + ox);
            p.y = rq.cy;
            p.z = clamp32(longint'(rq.cz) + oz);
            p.index = i[5:0];
            p.last = (i == n - 1);
            ring_points_q.push_back(p);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (point_count_we)
                count_mirror = point_count_data;
            if (!(start && busy)) begin
                if (start)
                    predict_ring_points(active_ring, count_mirror);
                if (ring_requests_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    active_ring = ring_requests_q.pop_front();
                    start <= 1'b1;
                    center_x <= active_ring.cx;
                    center_y <= active_ring.cy;
                    center_z <= active_ring.cz;
                    ring_radius <= active_ring.radius;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        point_t e;
        if (rst_n && point_valid) begin
            if (ring_points_q.size() == 0) begin
                $display("%0t: unexpected point x=%h y=%h z=%h idx=%0d last=%b", $time,
                         point_x, point_y, point_z, point_index, last_point);
                mismatches++;
            end
            else begin
                e = ring_points_q.pop_front();
                if (point_x !== e.x || point_y !== e.y || point_z !== e.z ||
                    point_index !== e.index || last_point !== e.last) begin
                    $display("%0t: expected x=%h y=%h z=%h idx=%0d last=%b", $time,
                             e.x, e.y, e.z, e.index, e.last);
                    $display("%0t: actual   x=%h y=%h z=%h idx=%0d last=%b", $time,
                             point_x, point_y, point_z, point_index, last_point);
                    mismatches++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (ring_requests_q.size() > 0 || start || ring_points_q.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_point_count(logic [6:0] v);
        wait_drained();
        point_count_we <= 1'b1;
        point_count_data <= v;
        @(posedge clk);
        point_count_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_ring(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [30:0] r);
        ring_t rq;
        rq.cx = cx;
        rq.cy = cy;
        rq.cz = cz;
        rq.radius = r;
        ring_requests_q.push_back(rq);
    endtask

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(32'h000FFFFF));
            2: return 31'h7FFFFFFF - 31'($urandom_range(255));
            default: return 31'($urandom_range(32'h03FFFFFF));
        endcase
    endfunction

    initial begin
        logic [6:0] cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of 16, field extremes
        queue_ring(32'h0, 32'h0, 32'h0, 31'h0);
        queue_ring(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
        queue_ring(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
        queue_ring(32'h00010000, 32'hFFFF0000, 32'hFFFFFFFF, 31'h00010000);
        write_point_count(7'd0);
        queue_ring(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 31'h55555555);
        queue_ring(32'hFFFFFFFF, 32'h00000001, 32'h80000000, 31'h2AAAAAAA);
        write_point_count(7'd1);
        queue_ring(32'h7FFFFFFF, 32'h5A5A5A5A, 32'h0, 31'h7FFFFFFF);
        queue_ring(32'h80000000, 32'hA5A5A5A5, 32'h0, 31'h00000001);
        write_point_count(7'd64);
        queue_ring(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF);
        queue_ring(32'h7FFF0000, 32'h1, 32'h80010000, 31'h40000000);
        write_point_count(7'd127);
        queue_ring(32'h0, 32'hFFFFFFFF, 32'h0, 31'h00640000);
        write_point_count(7'd65);
        queue_ring(32'h80000000, 32'h0, 32'h7FFFFFFF, 31'h7FFFFFFF);
        write_point_count(7'd3);
        queue_ring(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF);
        queue_ring(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 31'h3FFFFFFF);
        write_point_count(7'd2);
        queue_ring(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF);
        write_point_count(7'd4);
        queue_ring(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF);

        for (int ph = 0; ph < 16; ph++) begin
            sender_idle_pct = (ph < 6) ? 24 : (ph < 11) ? 69 : 0;
            case ($urandom_range(9))
                0: cnt = 7'd0;
                1: cnt = 7'($urandom_range(127, 64));
                2: cnt = 7'd1;
                default: cnt = 7'($urandom_range(16, 1));
            endcase
            write_point_count(cnt);
            for (int k = 0; k < 10; k++)
                queue_ring($urandom, $urandom, $urandom, rand_radius());
        end
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/cpg_pkg.sv
design/cpg_step_div.sv
design/cpg_cordic.sv
design/cpg_scale.sv
design/circle_point_generator.sv
test/tb.sv
